@@ sv/patan2_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// patan2_pkg
// Widths, fixed-point constants, coefficients and the shared rounding helper
// for the pipelined polynomial atan2 block.
// ============================================================================
package patan2_pkg;

  // Sample and angle formats
  localparam int SAMPLE_WIDTH        = 16;
  localparam int ANGLE_FRACTION_BITS = 20;
  localparam int ANGLE_W             = ANGLE_FRACTION_BITS + 3;

  // Stream widths: fields packed from bit 0, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ANGLE_W + 7) / 8) * 8;

  // Internal Q30 arithmetic
  localparam int QF     = 30;
  localparam int QW     = QF + 1;             // ratio and ratio squared, <= 1.0
  localparam int ACC_W  = QF + 3;             // signed accumulator, holds pi
  localparam int PROD_W = ACC_W + QW;         // accumulator times ratio
  localparam int NUM_W  = SAMPLE_WIDTH + QF;  // dividend small*2^30 + big/2

  // Pipeline shape after the divider
  localparam int NUM_COEF = 7;
  localparam int NPL      = 2 * NUM_COEF + 4;

  localparam logic [PROD_W-1:0] Q_HALF = PROD_W'(1) << (QF - 1);
  localparam logic [ACC_W-1:0]  ANG_HALF = ACC_W'(1) << (QF - ANGLE_FRACTION_BITS - 1);

  localparam logic signed [ACC_W-1:0] PI_Q      = ACC_W'(64'sd3373259426);
  localparam logic signed [ACC_W-1:0] HALF_PI_Q = ACC_W'(64'sd1686629713);

  localparam longint COEF_INT [NUM_COEF] = '{
    64'sd7744777,
    -64'sd37645046,
    64'sd87698811,
    -64'sd143609290,
    64'sd213208227,
    -64'sd357824448,
    64'sd1073741824
  };

  typedef struct packed {
    logic ybig;
    logic xneg;
    logic yneg;
    logic zero;
  } side_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] ay;
    logic [SAMPLE_WIDTH-1:0] ax;
    logic                    yneg;
    logic                    xneg;
  } mag_t;

  typedef struct packed {
    side_t                   side;
    logic [SAMPLE_WIDTH-1:0] rem;
    logic [SAMPLE_WIDTH-1:0] big;
    logic [QW-1:0]           num;
    logic [QW-1:0]           quo;
  } div_t;

  typedef struct packed {
    side_t                     side;
    logic [QW-1:0]             r;
    logic [QW-1:0]             r2;
    logic signed [ACC_W-1:0]   acc;
    logic signed [PROD_W-1:0]  prod;
    logic [ANGLE_W-1:0]        angle;
  } poly_t;

  // Round a Q60 product to Q30, to nearest with ties away from zero
  function automatic logic signed [ACC_W-1:0] q_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + Q_HALF - PROD_W'(p[PROD_W-1]);
    t = t >>> QF;
    return t[ACC_W-1:0];
  endfunction

endpackage

@@ sv/polynomial_atan2_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// polynomial_atan2_top
// Four-quadrant atan2(y, x) in radians, 20 fraction bits, by a pipelined
// restoring divider and a Horner evaluation of an odd minimax polynomial.
// ============================================================================
// Pipeline: 1 magnitude stage, 32 divider stages, 18 polynomial/reflection
// stages and 1 output register. Throughput: one item per cycle while the skid
// entry is free, set by the fully pipelined divider (one quotient bit per stage)
// and one multiply per stage.
// A waiting result takes the skid entry; then the pipeline and in_tready hold.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
module polynomial_atan2_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata fields, low bit up: y_value[15:0], x_value[31:16]
  input  logic [patan2_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata fields, low bit up: angle[22:0], zero pad
  output logic [patan2_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import patan2_pkg::*;

  // Global advance: the whole pipeline moves while the skid entry is free
  logic pipe_en;

  // Magnitude stage
  mag_t mg_r, mg_nxt;
  logic mg_v_r;

  // Divider stages: index 0 loads, 1..QW each resolve one quotient bit
  div_t div_r   [0:QW];
  div_t div_nxt [0:QW];
  logic div_v_r [0:QW];

  // Polynomial and reflection stages
  poly_t pl_r   [0:NPL-1];
  poly_t pl_nxt [0:NPL-1];
  logic  pl_v_r [0:NPL-1];

  // Output register and skid entry
  logic [ANGLE_W-1:0] out_r, skid_r;
  logic               out_v_r, skid_v_r;
  logic               push, take;

  assign pipe_en   = !skid_v_r;
  assign in_tready = pipe_en;

  // --------------------------------------------------------------------------
  // Stage: unpack and take magnitudes; the most negative sample maps exactly
  // --------------------------------------------------------------------------
  always_comb begin
    logic [SAMPLE_WIDTH-1:0] y, x;
    y = in_tdata[SAMPLE_WIDTH-1:0];
    x = in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    mg_nxt.yneg = y[SAMPLE_WIDTH-1];
    mg_nxt.xneg = x[SAMPLE_WIDTH-1];
    mg_nxt.ay   = y[SAMPLE_WIDTH-1] ? (~y + SAMPLE_WIDTH'(1)) : y;
    mg_nxt.ax   = x[SAMPLE_WIDTH-1] ? (~x + SAMPLE_WIDTH'(1)) : x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mg_v_r <= 1'b0;
    end else if (pipe_en) begin
      mg_v_r <= in_tvalid;
    end
    if (pipe_en) begin
      mg_r <= mg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divider load: pick larger magnitude as divisor, form rounded dividend
  // small*2^30 + big/2. Equal magnitudes count as |y| not greater.
  // --------------------------------------------------------------------------
  always_comb begin
    logic                    ybig;
    logic [SAMPLE_WIDTH-1:0] big, small_mag;
    logic [NUM_W-1:0]        n;
    ybig      = mg_r.ay > mg_r.ax;
    big       = ybig ? mg_r.ay : mg_r.ax;
    small_mag = ybig ? mg_r.ax : mg_r.ay;
    n = (NUM_W'(small_mag) << QF) + NUM_W'(big >> 1);
    div_nxt[0].side.ybig = ybig;
    div_nxt[0].side.xneg = mg_r.xneg;
    div_nxt[0].side.yneg = mg_r.yneg;
    div_nxt[0].side.zero = (big == '0);
    div_nxt[0].big       = big;
    div_nxt[0].rem       = {1'b0, n[NUM_W-1:QW]};
    div_nxt[0].num       = n[QW-1:0];
    div_nxt[0].quo       = '0;
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_comb begin
      logic [SAMPLE_WIDTH:0] t, d;
      logic                  ge;
      t  = {div_r[k-1].rem, div_r[k-1].num[QW-1]};
      d  = t - {1'b0, div_r[k-1].big};
      ge = (t >= {1'b0, div_r[k-1].big});
      div_nxt[k]     = div_r[k-1];
      div_nxt[k].rem = ge ? d[SAMPLE_WIDTH-1:0] : t[SAMPLE_WIDTH-1:0];
      div_nxt[k].num = div_r[k-1].num << 1;
      div_nxt[k].quo = {div_r[k-1].quo[QW-2:0], ge};
    end
  end

  for (genvar k = 0; k <= QW; k++) begin : g_div_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[k] <= 1'b0;
      end else if (pipe_en) begin
        div_v_r[k] <= (k == 0) ? mg_v_r : div_v_r[(k == 0) ? 0 : k-1];
      end
      if (pipe_en) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Polynomial stages: square, six Horner multiply/add pairs, times r,
  // octant and quadrant reflection, final rounding and sign.
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < NPL; s++) begin : g_pl
    if (s == 0) begin : g_sq
      always_comb begin
        logic [2*QW-1:0] sq;
        sq = div_r[QW].quo * div_r[QW].quo;
        pl_nxt[s]       = '0;
        pl_nxt[s].side  = div_r[QW].side;
        pl_nxt[s].r     = div_r[QW].quo;
        pl_nxt[s].prod  = PROD_W'(sq);
      end
    end else if (s == 1) begin : g_r2
      always_comb begin
        logic [PROD_W-1:0] t;
        t = $unsigned(pl_r[s-1].prod) + Q_HALF;
        pl_nxt[s]     = pl_r[s-1];
        pl_nxt[s].r2  = t[QF+QW-1:QF];
        pl_nxt[s].acc = ACC_W'(COEF_INT[0]);
      end
    end else if (s < 2 * NUM_COEF && (s % 2) == 0) begin : g_hmul
      always_comb begin
        pl_nxt[s]      = pl_r[s-1];
        pl_nxt[s].prod = pl_r[s-1].acc * $signed({1'b0, pl_r[s-1].r2});
      end
    end else if (s < 2 * NUM_COEF) begin : g_hadd
      always_comb begin
        pl_nxt[s]     = pl_r[s-1];
        pl_nxt[s].acc = q_round(pl_r[s-1].prod) + ACC_W'(COEF_INT[s/2]);
      end
    end else if (s == 2 * NUM_COEF) begin : g_rmul
      always_comb begin
        pl_nxt[s]      = pl_r[s-1];
        pl_nxt[s].prod = pl_r[s-1].acc * $signed({1'b0, pl_r[s-1].r});
      end
    end else if (s == 2 * NUM_COEF + 1) begin : g_oct
      // Round the first-octant angle, mirror to pi/2 minus it when |y| > |x|
      always_comb begin
        logic signed [ACC_W-1:0] a;
        a = q_round(pl_r[s-1].prod);
        pl_nxt[s]     = pl_r[s-1];
        pl_nxt[s].acc = pl_r[s-1].side.ybig ? (HALF_PI_Q - a) : a;
      end
    end else if (s == 2 * NUM_COEF + 2) begin : g_quad
      // Mirror to pi minus it for negative x, clamp below at zero
      always_comb begin
        logic signed [ACC_W-1:0] a;
        a = pl_r[s-1].side.xneg ? (PI_Q - pl_r[s-1].acc) : pl_r[s-1].acc;
        pl_nxt[s]     = pl_r[s-1];
        pl_nxt[s].acc = (a < 0) ? '0 : a;
      end
    end else begin : g_fin
      // Round Q30 magnitude to output fraction bits, then apply the y sign
      always_comb begin
        logic [ACC_W-1:0] m;
        m = ($unsigned(pl_r[s-1].acc) + ANG_HALF) >> (QF - ANGLE_FRACTION_BITS);
        pl_nxt[s] = pl_r[s-1];
        if (pl_r[s-1].side.zero) begin
          pl_nxt[s].angle = '0;
        end else if (pl_r[s-1].side.yneg) begin
          pl_nxt[s].angle = ANGLE_W'(ACC_W'(0) - m);
        end else begin
          pl_nxt[s].angle = ANGLE_W'(m);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pl_v_r[s] <= 1'b0;
      end else if (pipe_en) begin
        pl_v_r[s] <= (s == 0) ? div_v_r[QW] : pl_v_r[(s == 0) ? 0 : s-1];
      end
      if (pipe_en) begin
        pl_r[s] <= pl_nxt[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid entry. The skid catches the item leaving the
  // pipeline while the output waits; a full skid holds the pipeline.
  // --------------------------------------------------------------------------
  assign push = pipe_en & pl_v_r[NPL-1];
  assign take = out_v_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end

    if (skid_v_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_v_r && !take) begin
        skid_r <= pl_r[NPL-1].angle;
      end else begin
        out_r <= pl_r[NPL-1].angle;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

endmodule

@@ sim/polynomial_atan2_top_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// polynomial_atan2_top_test
// Streams signed (y, x) sample pairs into the atan2 pipeline and checks every
// angle against a bit-exact Q30 fixed-point prediction, in order. Both stream
// sides idle at random, with some stretches of full-rate traffic.
// ============================================================================
module polynomial_atan2_top_test;

  import patan2_pkg::SAMPLE_WIDTH;
  import patan2_pkg::ANGLE_W;
  import patan2_pkg::IN_TDATA_W;
  import patan2_pkg::OUT_TDATA_W;

  // Q30 constants used by the prediction
  localparam int          FRAC_Q      = 30;
  localparam logic [63:0] Q30_ONE     = 64'd1 << FRAC_Q;
  localparam logic [63:0] Q30_HALF    = 64'd1 << (FRAC_Q - 1);
  localparam longint      PI_Q30      = 64'sd3373259426;
  localparam longint      HALF_PI_Q30 = 64'sd1686629713;
  localparam int          ANGLE_SHIFT = FRAC_Q - 20;

  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] x_value;
    logic [SAMPLE_WIDTH-1:0] y_value;
  } sample_pair_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  sample_pair_t       sample_q[$];  // pairs waiting to be driven
  logic [ANGLE_W-1:0] angle_q[$];   // predicted angles, oldest first

  int mismatches = 0;
  int sent_count = 0;
  int recv_count = 0;
  int send_gap = 0;
  int recv_stall = 0;

  polynomial_atan2_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Magnitude of a two's complement sample; the most negative value maps to 2^15
  function automatic logic [63:0] sample_abs(input logic [SAMPLE_WIDTH-1:0] raw);
    logic [SAMPLE_WIDTH-1:0] neg_raw;
    neg_raw = ~raw + 1'b1;
    return raw[SAMPLE_WIDTH-1] ? 64'(neg_raw) : 64'(raw);
  endfunction

  // Signed Q30 times unsigned Q30, rounded to nearest with ties away from zero
  function automatic longint q30_scale(input longint a, input logic [63:0] b);
    logic        neg;
    logic [63:0] m;
    logic [63:0] p;
    neg = a < 0;
    m = neg ? 64'(-a) : 64'(a);
    p = (m * b + Q30_HALF) >> FRAC_Q;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // Four-quadrant angle of (y, x) with 20 fraction bits
  function automatic logic [ANGLE_W-1:0] atan2_fixed(input logic [SAMPLE_WIDTH-1:0] y_raw,
                                                     input logic [SAMPLE_WIDTH-1:0] x_raw);
    logic [63:0]        ay;
    logic [63:0]        ax;
    logic [63:0]        big;
    logic [63:0]        tiny;
    logic [63:0]        ratio;
    logic [63:0]        ratio_sq;
    logic [63:0]        mag;
    logic [ANGLE_W-1:0] mag_w;
    logic               y_big;
    longint             acc;
    longint             coef;
    longint             ang;
    ay = sample_abs(y_raw);
    ax = sample_abs(x_raw);
    y_big = ay > ax;
    big = y_big ? ay : ax;
    tiny = y_big ? ax : ay;
    if (big == 0) begin
      return '0;
    end
    ratio = ((tiny << FRAC_Q) + (big >> 1)) / big;
    if (ratio > Q30_ONE) begin
      ratio = Q30_ONE;
    end
    ratio_sq = (ratio * ratio + Q30_HALF) >> FRAC_Q;
    acc = 64'sd7744777;
    for (int k = 1; k < 7; k++) begin
      case (k)
        1: coef = -64'sd37645046;
        2: coef = 64'sd87698811;
        3: coef = -64'sd143609290;
        4: coef = 64'sd213208227;
        5: coef = -64'sd357824448;
        default: coef = 64'sd1073741824;
      endcase
      acc = q30_scale(acc, ratio_sq) + coef;
    end
    ang = q30_scale(acc, ratio);
    if (y_big) begin
      ang = HALF_PI_Q30 - ang;
    end
    if (x_raw[SAMPLE_WIDTH-1]) begin
      ang = PI_Q30 - ang;
    end
    if (ang < 0) begin
      ang = 0;
    end
    mag = (64'(ang) + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;
    mag_w = mag[ANGLE_W-1:0];
    return y_raw[SAMPLE_WIDTH-1] ? -mag_w : mag_w;
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Driver: advance to the next pair once the current transfer is done,
  // inserting random idle cycles between pairs.
  always @(posedge clk) begin
    sample_pair_t pair;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        angle_q.push_back(atan2_fixed(in_tdata[SAMPLE_WIDTH-1:0],
                                      in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          pair = sample_q.pop_front();
          in_tdata <= IN_TDATA_W'(pair);
          in_tvalid <= 1'b1;
          // Full-rate stretch for a quarter of every 400 pairs
          send_gap = ((sent_count % 400) >= 300) ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall out_tready at random and check each transfer against the
  // oldest predicted angle.
  always @(posedge clk) begin
    logic [ANGLE_W-1:0] want;
    logic [ANGLE_W-1:0] got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[ANGLE_W-1:0];
        recv_count++;
        if (angle_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected angle transfer: got %0d", $signed(got));
          end
        end else begin
          want = angle_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("angle mismatch at result %0d: expected %0d actual %0d",
                       recv_count - 1, $signed(want), $signed(got));
            end
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        // Hold ready high through the first fifth of every 500 results
        recv_stall = ((recv_count % 500) < 100) ? 0 : pick_gap();
      end
    end
  end

  // Load the pair queue, release reset, then wait for the pipeline to drain
  initial begin
    logic [SAMPLE_WIDTH-1:0] yv;
    logic [SAMPLE_WIDTH-1:0] xv;
    logic [63:0]             ym;
    sample_pair_t            pair;

    // Directed: origin, axes, diagonals, most negative samples, tiny ratios
    sample_q.push_back('{x_value: 16'sd0,      y_value: 16'sd0});
    sample_q.push_back('{x_value: 16'sd100,    y_value: 16'sd0});
    sample_q.push_back('{x_value: -16'sd100,   y_value: 16'sd0});
    sample_q.push_back('{x_value: 16'sd0,      y_value: 16'sd77});
    sample_q.push_back('{x_value: 16'sd0,      y_value: -16'sd77});
    sample_q.push_back('{x_value: 16'sd32767,  y_value: 16'sd32767});
    sample_q.push_back('{x_value: -16'sd32768, y_value: -16'sd32768});
    sample_q.push_back('{x_value: 16'sd32767,  y_value: -16'sd32768});
    sample_q.push_back('{x_value: -16'sd32768, y_value: 16'sd32767});
    sample_q.push_back('{x_value: 16'sd0,      y_value: -16'sd32768});
    sample_q.push_back('{x_value: -16'sd32768, y_value: 16'sd0});
    sample_q.push_back('{x_value: 16'sd1,      y_value: 16'sd1});
    sample_q.push_back('{x_value: -16'sd1,     y_value: -16'sd1});
    sample_q.push_back('{x_value: -16'sd1,     y_value: 16'sd1});
    sample_q.push_back('{x_value: 16'sd1,      y_value: -16'sd1});
    sample_q.push_back('{x_value: 16'sd32767,  y_value: 16'sd1});
    sample_q.push_back('{x_value: 16'sd1,      y_value: 16'sd32767});
    sample_q.push_back('{x_value: -16'sd32768, y_value: -16'sd1});
    sample_q.push_back('{x_value: -16'sd1,     y_value: -16'sd32768});
    sample_q.push_back('{x_value: -16'sd23456, y_value: 16'sd12345});
    sample_q.push_back('{x_value: 16'sd20000,  y_value: -16'sd20001});
    sample_q.push_back('{x_value: -16'sd32767, y_value: 16'sd32767});
    sample_q.push_back('{x_value: 16'sd0,      y_value: 16'sd32767});

    // Random: full range, small magnitudes, near diagonals, axes, extremes, lopsided
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      yv = $urandom;
      xv = $urandom;
      case ($urandom_range(9))
        0, 1, 2, 3: begin
        end
        4: begin
          yv = SAMPLE_WIDTH'($urandom_range(16) - 8);
          xv = SAMPLE_WIDTH'($urandom_range(16) - 8);
        end
        5: begin
          // |x| close to |y|, either side of the diagonal
          ym = sample_abs(yv);
          xv = SAMPLE_WIDTH'(ym + $urandom_range(4) - 2);
          if ($urandom_range(1)) begin
            xv = ~xv + 1'b1;
          end
        end
        6: begin
          if ($urandom_range(1)) begin
            yv = '0;
          end else begin
            xv = '0;
          end
        end
        7: begin
          yv = $urandom_range(1) ? 16'h8000 : 16'h7fff;
          if ($urandom_range(1)) begin
            xv = $urandom_range(1) ? 16'h8000 : 16'h7fff;
          end
        end
        default: begin
          // one component much larger than the other
          if ($urandom_range(1)) begin
            yv = SAMPLE_WIDTH'($urandom_range(6) - 3);
          end else begin
            xv = SAMPLE_WIDTH'($urandom_range(6) - 3);
          end
        end
      endcase
      pair.y_value = yv;
      pair.x_value = xv;
      sample_q.push_back(pair);
    end

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (sample_q.size() > 0 || in_tvalid || angle_q.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with the longest gaps and stalls
  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ polynomial_atan2_top.f @@
sv/patan2_pkg.sv
sv/polynomial_atan2_top.sv
sim/polynomial_atan2_top_test.sv
